FILE: rtl/kc3_pkg.sv
// ----------------------------------------------------------------------------
// kc3_pkg: shared types and constants of the 3x3 convolution filter
// Transaction structs, register indexes, kernel weights and divider constants.
// ----------------------------------------------------------------------------
package kc3_pkg;

  // Register widths and geometry limits
  localparam int unsigned WIDTH_W       = 11;
  localparam int unsigned HEIGHT_W      = 13;
  localparam int unsigned CFG_DATA_W    = 13;
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned MODE_W        = 3;
  localparam int unsigned HEIGHT_LIMIT  = 4096;
  localparam int unsigned ROW_W         = 14;  // drain rows and geometry edits overshoot h
  localparam int unsigned COL_CMP_W     = 12;
  localparam int unsigned COUNT_W       = 23;
  localparam int unsigned SUM_W         = 13;

  localparam int unsigned MAX_WIDTH_DEFAULT = 1024;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 13'd480;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_MODE  = 2'd2;

  // Kernel modes; codes above the last one select the box kernel
  localparam logic [MODE_W-1:0] MODE_BOX       = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LAPLACIAN = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SHARPEN   = 3'd2;
  localparam logic [MODE_W-1:0] MODE_EDGE      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_GAUSSIAN  = 3'd4;

  // Input commands
  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  // ceil(2^16 / 9); exact floor(m / 9) for every m below 4096
  localparam int unsigned DIV9_RECIP = 7282;
  localparam int unsigned DIV9_SHIFT = 16;

  // Output queue
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OUT_PTR_W = 2;
  localparam int unsigned PEND_W    = 3;

  typedef struct packed {
    logic       command;
    logic [7:0] pixel_value;
  } kc3_in_t;

  typedef struct packed {
    logic signed [9:0] filtered_value;
    logic              frame_end;
  } kc3_out_t;

  // Taps that fall outside the image
  typedef struct packed {
    logic top;
    logic bottom;
    logic left;
    logic right;
  } kc3_border_t;

  // Per-transaction control handed from the raster counters to the datapath
  typedef struct packed {
    logic        process;
    logic        emit;
    kc3_border_t border;
    logic        frame_end;
    logic [7:0]  value;
  } kc3_s0_t;

  // New window column: upper row, middle row, current row
  typedef struct packed {
    logic [7:0] top;
    logic [7:0] mid;
    logic [7:0] bot;
  } kc3_col_t;

  function automatic logic signed [3:0] kc3_weight(input logic [MODE_W-1:0] mode,
                                                   input int unsigned row,
                                                   input int unsigned col);
    logic is_center;
    logic is_corner;
    logic signed [3:0] w;
    is_center = (row == 1) && (col == 1);
    is_corner = (row != 1) && (col != 1);
    unique case (mode)
      MODE_LAPLACIAN: w = is_center ? -4'sd4 : (is_corner ? 4'sd0 : 4'sd1);
      MODE_SHARPEN:   w = is_center ? 4'sd5 : (is_corner ? 4'sd0 : -4'sd1);
      MODE_EDGE:      w = is_center ? 4'sd5 : -4'sd1;
      MODE_GAUSSIAN:  w = is_center ? 4'sd4 : (is_corner ? 4'sd1 : 4'sd2);
      default:        w = 4'sd1;
    endcase
    return w;
  endfunction

endpackage

FILE: rtl/kc3_ctrl.sv
// ----------------------------------------------------------------------------
// kc3_ctrl: configuration registers and raster counters
// Tracks column, row and output count, decides which transactions emit.
// ----------------------------------------------------------------------------
module kc3_ctrl #(
  parameter int unsigned MAX_WIDTH = kc3_pkg::MAX_WIDTH_DEFAULT,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kc3_pkg::CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [kc3_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,
  input  logic                               accept_i,
  input  kc3_pkg::kc3_in_t                   in_data_i,
  output kc3_pkg::kc3_s0_t                   s0_o,
  output logic [AW-1:0]                      rd_addr_o,
  output logic [kc3_pkg::MODE_W-1:0]         mode_o
);

  localparam int unsigned WW = kc3_pkg::WIDTH_W;
  localparam int unsigned HW = kc3_pkg::HEIGHT_W;
  localparam int unsigned YW = kc3_pkg::ROW_W;
  localparam int unsigned CW = kc3_pkg::COL_CMP_W;
  localparam int unsigned NW = kc3_pkg::COUNT_W;

  logic [WW-1:0] width_q, width_d, new_w;
  logic [HW-1:0] height_q, height_d, new_h;
  logic [kc3_pkg::MODE_W-1:0] mode_q, mode_d;
  logic [NW-1:0] total_q, total_d;
  logic [WW-1:0] mul_a;
  logic [HW-1:0] mul_b;
  logic [WW+HW-1:0] prod;

  logic [AW-1:0] x_q, x_d, x_e;
  logic [YW-1:0] y_q, y_d, y_e;
  logic [NW-1:0] oc_q, oc_d, oc_e, oc_inc;
  logic restart, pushing, drop, xz, emit, last_col, fend;

  // Clamp incoming geometry and refresh the pixel total with one multiply
  always_comb begin
    if (cfg_wdata_i[WW-1:0] == '0) begin
      new_w = WW'(1);
    end else if (32'(cfg_wdata_i[WW-1:0]) > MAX_WIDTH) begin
      new_w = WW'(MAX_WIDTH);
    end else begin
      new_w = cfg_wdata_i[WW-1:0];
    end
    if (cfg_wdata_i == '0) begin
      new_h = HW'(1);
    end else if (32'(cfg_wdata_i) > kc3_pkg::HEIGHT_LIMIT) begin
      new_h = HW'(kc3_pkg::HEIGHT_LIMIT);
    end else begin
      new_h = cfg_wdata_i;
    end

    width_d  = width_q;
    height_d = height_q;
    mode_d   = mode_q;
    mul_a    = width_q;
    mul_b    = height_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        kc3_pkg::REG_IMAGE_WIDTH: begin
          width_d = new_w;
          mul_a   = new_w;
        end
        kc3_pkg::REG_IMAGE_HEIGHT: begin
          height_d = new_h;
          mul_b    = new_h;
        end
        kc3_pkg::REG_KERNEL_MODE: mode_d = cfg_wdata_i[kc3_pkg::MODE_W-1:0];
        default: ;
      endcase
    end
    prod    = {{HW{1'b0}}, mul_a} * {{WW{1'b0}}, mul_b};
    total_d = prod[NW-1:0];
  end

  // Raster position of this transaction
  always_comb begin
    restart = (oc_q >= total_q);
    x_e     = restart ? '0 : x_q;
    y_e     = restart ? '0 : y_q;
    oc_e    = restart ? '0 : oc_q;

    pushing = (y_e < YW'(height_q));
    drop    = (in_data_i.command == kc3_pkg::CMD_DRAIN) && pushing;
    xz      = (x_e == '0);
    emit    = (y_e >= YW'(2)) || ((y_e == YW'(1)) && !xz);
    last_col = ((CW'(x_e) + CW'(1)) >= CW'(width_q));
    oc_inc  = oc_e + NW'(1);
    fend    = emit && (oc_inc >= total_q);

    s0_o.process       = accept_i && !drop;
    s0_o.emit          = emit;
    s0_o.frame_end     = fend;
    s0_o.value         = pushing ? in_data_i.pixel_value : 8'd0;
    s0_o.border.top    = xz ? (y_e == YW'(2)) : (y_e == YW'(1));
    s0_o.border.bottom = xz ? (y_e >= (YW'(height_q) + YW'(1))) : (y_e >= YW'(height_q));
    s0_o.border.left   = xz ? (width_q == WW'(1)) : (x_e == AW'(1));
    // A width cut mid-row can leave the column at or past the new right edge
    s0_o.border.right  = xz || (CW'(x_e) >= CW'(width_q));

    x_d  = x_q;
    y_d  = y_q;
    oc_d = oc_q;
    if (accept_i) begin
      x_d  = x_e;
      y_d  = y_e;
      oc_d = oc_e;
      if (!drop) begin
        if (fend) begin
          x_d  = '0;
          y_d  = '0;
          oc_d = '0;
        end else begin
          x_d  = last_col ? '0 : AW'(x_e + AW'(1));
          y_d  = last_col ? YW'(y_e + YW'(1)) : y_e;
          oc_d = emit ? oc_inc : oc_e;
        end
      end
    end
  end

  assign rd_addr_o = x_e;
  assign mode_o    = mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= kc3_pkg::WIDTH_RESET;
      height_q <= kc3_pkg::HEIGHT_RESET;
      mode_q   <= kc3_pkg::MODE_BOX;
      total_q  <= NW'(32'(kc3_pkg::WIDTH_RESET) * 32'(kc3_pkg::HEIGHT_RESET));
      x_q      <= '0;
      y_q      <= '0;
      oc_q     <= '0;
    end else begin
      width_q  <= width_d;
      height_q <= height_d;
      mode_q   <= mode_d;
      total_q  <= total_d;
      x_q      <= x_d;
      y_q      <= y_d;
      oc_q     <= oc_d;
    end
  end

endmodule

FILE: rtl/kc3_line_mem.sv
// ----------------------------------------------------------------------------
// kc3_line_mem: two-row line store
// One synchronous memory holds both previous rows per column; read, shift
// and write back, with forwarding when a write and a read hit one column.
// ----------------------------------------------------------------------------
module kc3_line_mem #(
  parameter int unsigned MAX_WIDTH = kc3_pkg::MAX_WIDTH_DEFAULT,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              process_i,
  input  logic [AW-1:0]     rd_addr_i,
  input  logic [7:0]        value_i,
  output kc3_pkg::kc3_col_t col_o
);

  // Entry layout: [15:8] row two above, [7:0] row above
  logic [15:0] mem_q [MAX_WIDTH];
  logic [15:0] rd_q;
  logic [15:0] fwd_q;
  logic        fwd_sel_q;
  logic        wr_en_q;
  logic [AW-1:0] wr_addr_q;
  logic [7:0]  wr_val_q;
  logic [15:0] cur;
  logic [15:0] wr_data;

  assign cur     = fwd_sel_q ? fwd_q : rd_q;
  assign wr_data = {cur[7:0], wr_val_q};

  assign col_o.top = cur[15:8];
  assign col_o.mid = cur[7:0];
  assign col_o.bot = wr_val_q;

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr_i];
    if (wr_en_q) begin
      mem_q[wr_addr_q] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_addr_q <= rd_addr_i;
    wr_val_q  <= value_i;
    fwd_q     <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_en_q   <= 1'b0;
      fwd_sel_q <= 1'b0;
    end else begin
      wr_en_q   <= process_i;
      fwd_sel_q <= wr_en_q && (wr_addr_q == rd_addr_i);
    end
  end

endmodule

FILE: rtl/kc3_filter.sv
// ----------------------------------------------------------------------------
// kc3_filter: window, weighted sum and divide by nine
// Shifts the 3x3 window, sums masked taps, then divides toward zero.
// ----------------------------------------------------------------------------
module kc3_filter (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  kc3_pkg::kc3_s0_t           s0_i,
  input  kc3_pkg::kc3_col_t          col_i,
  input  logic [kc3_pkg::MODE_W-1:0] mode_i,
  output logic                       push_o,
  output kc3_pkg::kc3_out_t          push_data_o
);

  localparam int unsigned SW = kc3_pkg::SUM_W;

  logic [7:0] win_q [3][3];
  logic [7:0] win_d [3][3];
  logic       v1_q;
  logic       emit1_q;
  logic       fend1_q;
  kc3_pkg::kc3_border_t border1_q;

  logic signed [SW-1:0] sum_d, sum_q;
  logic v2_q;
  logic fend2_q;

  logic [11:0] mag;
  logic [24:0] prod;
  logic [8:0]  quot;

  // Shift in the new column and sum over the updated window
  always_comb begin
    logic skip;
    for (int i = 0; i < 3; i++) begin
      win_d[i][0] = win_q[i][1];
      win_d[i][1] = win_q[i][2];
    end
    win_d[0][2] = col_i.top;
    win_d[1][2] = col_i.mid;
    win_d[2][2] = col_i.bot;

    sum_d = '0;
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        skip = (i == 0 && border1_q.top) || (i == 2 && border1_q.bottom) ||
               (j == 0 && border1_q.left) || (j == 2 && border1_q.right);
        if (!skip) begin
          sum_d = sum_d + signed'({5'd0, win_d[i][j]}) *
                  SW'(kc3_pkg::kc3_weight(mode_i, i, j));
        end
      end
    end
  end

  // Divide magnitude by nine through the reciprocal, restore the sign
  always_comb begin
    mag  = sum_q[SW-1] ? 12'(-sum_q) : sum_q[11:0];
    prod = {13'd0, mag} * 25'(kc3_pkg::DIV9_RECIP);
    quot = prod[24:kc3_pkg::DIV9_SHIFT];
    push_data_o.filtered_value = sum_q[SW-1] ? -signed'({1'b0, quot}) : signed'({1'b0, quot});
    push_data_o.frame_end      = fend2_q;
  end

  assign push_o = v2_q;

  always_ff @(posedge clk_i) begin
    emit1_q   <= s0_i.emit;
    fend1_q   <= s0_i.frame_end;
    border1_q <= s0_i.border;
    sum_q     <= sum_d;
    fend2_q   <= fend1_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          win_q[i][j] <= 8'd0;
        end
      end
    end else begin
      v1_q <= s0_i.process;
      v2_q <= v1_q && emit1_q;
      if (v1_q) begin
        win_q <= win_d;
      end
    end
  end

endmodule

FILE: rtl/kc3_out_fifo.sv
// ----------------------------------------------------------------------------
// kc3_out_fifo: result queue
// Small register queue that decouples the filter pipeline from the receiver.
// ----------------------------------------------------------------------------
module kc3_out_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  kc3_pkg::kc3_out_t push_data_i,
  input  logic              pop_i,
  output logic              valid_o,
  output kc3_pkg::kc3_out_t data_o
);

  localparam int unsigned PW = kc3_pkg::OUT_PTR_W;

  kc3_pkg::kc3_out_t entry_q [kc3_pkg::OUT_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;

  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PW'(1);
      end
      count_q <= count_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
    end
  end

endmodule

FILE: rtl/kernel3x3_convolution.sv
// ----------------------------------------------------------------------------
// kernel3x3_convolution: zero-padded 3x3 filter over a grey raster stream
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one transaction per
// raster pixel (command push) or drain item. Drain items after the last
// pixel flush the outputs still owed; a drain while pixels remain is taken
// and ignored. Output channel (out_valid_o / out_stall_i / out_data_o): one
// transaction per output pixel, frame_end set on the last pixel of a frame.
// Output k comes from the input transaction that carries pixel k + width + 1.
// Results pass the line memory read, sum and queue registers. Throughput:
// one transaction per cycle while in_stall_o is low, set by the single
// read-modify-write of the line memory per column. A four-entry result
// queue sits in front of the receiver; in_stall_o rises only when four
// accepted results are not yet delivered, so a stalled receiver holds the
// input back and nothing is lost. Reset: geometry 640 x 480, box kernel,
// counters and window cleared. The line memory is not cleared; entries
// that reach a result are always written earlier in the same frame.
// Configuration must be written only while idle; the block does not check.
// ----------------------------------------------------------------------------
module kernel3x3_convolution #(
  parameter int unsigned MAX_WIDTH = kc3_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [kc3_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [kc3_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  kc3_pkg::kc3_in_t                in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output kc3_pkg::kc3_out_t               out_data_o
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned PEW = kc3_pkg::PEND_W;

  logic in_accept;
  logic out_pop;
  kc3_pkg::kc3_s0_t s0;
  logic [AW-1:0] rd_addr;
  logic [kc3_pkg::MODE_W-1:0] mode;
  kc3_pkg::kc3_col_t col;
  logic push;
  kc3_pkg::kc3_out_t push_data;

  // Results accepted but not yet delivered: in the pipe or in the queue
  logic [PEW-1:0] pending_q, pending_d;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_pop    = out_valid_o && !out_stall_i;
  assign in_stall_o = (pending_q >= PEW'(kc3_pkg::OUT_DEPTH));

  assign pending_d = pending_q + PEW'(s0.process && s0.emit) - PEW'(out_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  // Raster counters and registers; start the line memory read
  kc3_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (in_accept),
    .in_data_i  (in_data_i),
    .s0_o       (s0),
    .rd_addr_o  (rd_addr),
    .mode_o     (mode)
  );

  // Fetch both previous rows of this column, write back the shifted pair
  kc3_line_mem #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .process_i(s0.process),
    .rd_addr_i(rd_addr),
    .value_i  (s0.value),
    .col_o    (col)
  );

  // Shift the window, sum, divide
  kc3_filter u_filter (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s0_i       (s0),
    .col_i      (col),
    .mode_i     (mode),
    .push_o     (push),
    .push_data_o(push_data)
  );

  // Hold results until the receiver takes them
  kc3_out_fifo u_out_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_data_i(push_data),
    .pop_i      (out_pop),
    .valid_o    (out_valid_o),
    .data_o     (out_data_o)
  );

  // The pending count never passes the queue depth
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= PEW'(kc3_pkg::OUT_DEPTH))
    else $error("pending result count exceeds queue depth");

  // A result on the output is always counted as pending
  a_valid_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pending_q != '0))
    else $error("output valid with no pending result");

  // An emitting transaction with no delivery raises the pending count
  a_pending_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0.process && s0.emit && !out_pop) |=> (pending_q == $past(pending_q) + PEW'(1)))
    else $error("pending count missed an emitting transaction");

  // A result is pushed once its transaction passes the v1 and v2 valid registers
  a_push_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0.process && s0.emit) |-> ##2 push)
    else $error("result did not reach the queue on time");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for kernel3x3_convolution
// Streams small raster frames, a few extreme geometries and noisy drain
// traffic through the filter under random sender gaps and receiver stalls,
// predicts every output pixel in the bench and compares it field by field.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import kc3_pkg::*;

  localparam int unsigned LINE_DEPTH    = MAX_WIDTH_DEFAULT;
  localparam int          DIVISOR       = 9;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS  = 450;
  localparam logic [MODE_W-1:0] MODE_TOP_CODE = 3'd7;  // out of range, acts as box

  // --------------------------------------------------------------------------
  // Clock, reset and DUT ports; every input is known from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i = '0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_stall_o;
  kc3_in_t                in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  kc3_out_t               out_data_o;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  kernel3x3_convolution DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  kc3_in_t     pixel_q[$];       // input transactions not yet offered
  kc3_out_t    result_q[$];      // predicted output pixels, oldest first
  kc3_out_t    next_result;
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  logic        in_fire        = 1'b0;  // input transaction taken at the last edge
  int unsigned error_count    = 0;

  // Filter mirror: registers, line memories, window and raster counters
  logic [WIDTH_W-1:0]  width_reg  = WIDTH_RESET;
  logic [HEIGHT_W-1:0] height_reg = HEIGHT_RESET;
  logic [MODE_W-1:0]   mode_reg   = MODE_BOX;
  logic [7:0]          row_prev  [LINE_DEPTH];  // row above the current one
  logic [7:0]          row_prev2 [LINE_DEPTH];  // two rows above
  logic [7:0]          win [3][3];              // [row][column], row 0 on top
  int unsigned         col_pos   = 0;
  int unsigned         row_pos   = 0;
  int unsigned         out_count = 0;

  // Weight of one tap, tap = 3 * row + column; unknown modes fall back to box
  function automatic int tap_weight(input logic [MODE_W-1:0] mode, input int tap);
    int w;
    case (mode)
      MODE_LAPLACIAN: begin
        case (tap)
          4:          w = -4;
          1, 3, 5, 7: w = 1;
          default:    w = 0;
        endcase
      end
      MODE_SHARPEN: begin
        case (tap)
          4:          w = 5;
          1, 3, 5, 7: w = -1;
          default:    w = 0;
        endcase
      end
      MODE_EDGE: begin
        w = (tap == 4) ? 5 : -1;
      end
      MODE_GAUSSIAN: begin
        case (tap)
          4:          w = 4;
          1, 3, 5, 7: w = 2;
          default:    w = 1;
        endcase
      end
      default: begin
        w = 1;
      end
    endcase
    return w;
  endfunction

  // Advance the mirror by one accepted input transaction and queue the
  // output pixel it releases, if any
  function automatic void predict_filter(input kc3_in_t item);
    int unsigned w, h, total, x, y, r, c, idx;
    int          i, j, sum, q;
    logic        live;
    logic [7:0]  value;
    kc3_out_t    res;
    w = (width_reg < 1) ? 1 : ((width_reg > LINE_DEPTH) ? LINE_DEPTH : width_reg);
    h = (height_reg < 1) ? 1 : ((height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : height_reg);
    total = w * h;
    // A geometry edit may leave the frame already complete: restart it
    if (out_count >= total) begin
      col_pos = 0;
      row_pos = 0;
      out_count = 0;
    end
    x = col_pos;
    y = row_pos;
    live = (y < h);
    // Drop a drain while pixels remain; a push past the last pixel drains
    if (item.command == CMD_DRAIN && live) return;
    value = live ? item.pixel_value : 8'd0;
    idx = x % LINE_DEPTH;
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = row_prev2[idx];
    win[1][2] = row_prev[idx];
    win[2][2] = value;
    row_prev2[idx] = row_prev[idx];
    row_prev[idx] = value;
    if (x + 1 >= w) begin
      col_pos = 0;
      row_pos = y + 1;
    end else begin
      col_pos = x + 1;
    end
    // Output pixels trail the input by one row plus one pixel
    if (!((y >= 2) || (y == 1 && x >= 1))) return;
    if (x == 0) begin
      c = w - 1;
      r = y - 2;
    end else begin
      c = x - 1;
      r = y - 1;
    end
    sum = 0;
    for (i = 0; i < 3; i++) begin
      for (j = 0; j < 3; j++) begin
        // Neighbors outside the image count as zero
        if (!(i == 0 && r == 0) && !(i == 2 && r + 1 >= h) &&
            !(j == 0 && c == 0) && !(j == 2 && c + 1 >= w)) begin
          sum += int'(win[i][j]) * tap_weight(mode_reg, 3 * i + j);
        end
      end
    end
    q = sum / DIVISOR;  // truncates toward zero
    out_count++;
    res.filtered_value = q[9:0];
    res.frame_end = (out_count >= total);
    result_q.push_back(res);
    if (out_count >= total) begin
      col_pos = 0;
      row_pos = 0;
      out_count = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Driver: offer the next pending transaction, hold it while stalled
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire) begin
      if (pixel_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_data_i  <= pixel_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_stall_i <= rst_ni && ($urandom_range(99) < recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Monitor: mirror register writes, predict on accepted input, check output
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid_i && !in_stall_o;
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  width_reg  = cfg_wdata_i[WIDTH_W-1:0];
          REG_IMAGE_HEIGHT: height_reg = cfg_wdata_i[HEIGHT_W-1:0];
          REG_KERNEL_MODE:  mode_reg   = cfg_wdata_i[MODE_W-1:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_o) predict_filter(in_data_i);
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("output transaction with nothing predicted: filtered_value %0d frame_end %0b",
                 out_data_o.filtered_value, out_data_o.frame_end);
          error_count++;
        end else begin
          next_result = result_q.pop_front();
          if (out_data_o.filtered_value !== next_result.filtered_value) begin
            $error("filtered_value: expected %0d, actual %0d",
                   next_result.filtered_value, out_data_o.filtered_value);
            error_count++;
          end
          if (out_data_o.frame_end !== next_result.frame_end) begin
            $error("frame_end: expected %0b, actual %0b",
                   next_result.frame_end, out_data_o.frame_end);
            error_count++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic void queue_item(input logic cmd, input logic [7:0] value);
    kc3_in_t it;
    it.command     = cmd;
    it.pixel_value = value;
    pixel_q.push_back(it);
  endfunction

  // Bias toward black and white so the extremes show up often
  function automatic logic [7:0] pick_pixel();
    logic [7:0] v;
    case ($urandom_range(9))
      0:       v = 8'h00;
      1:       v = 8'hFF;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Wait until every transaction is sent and every output has arrived, then
  // let the pipeline drain items that produce nothing
  task automatic settle();
    while (pixel_q.size() != 0 || in_valid_i || result_q.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input int unsigned value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_wdata_i <= value[CFG_DATA_W-1:0];
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input logic [MODE_W-1:0] mode);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_KERNEL_MODE, mode);
  endtask

  // Queue one frame of w x h pixels followed by the w + 1 drains it needs.
  // Noisy frames scatter ignored drains, pushes in the drain tail and stray
  // drains after the frame. A nonzero split pauses the stream at that pixel,
  // lets everything drain, and switches the kernel mid-frame.
  task automatic queue_frame(input int unsigned w, input int unsigned h,
                             input logic noisy, input int unsigned split);
    int unsigned n;
    for (n = 0; n < w * h; n++) begin
      if (split != 0 && n == split) begin
        settle();
        write_reg(REG_KERNEL_MODE, $urandom_range(7));
      end
      if (noisy && $urandom_range(9) == 0) queue_item(CMD_DRAIN, pick_pixel());
      queue_item(CMD_PUSH, pick_pixel());
    end
    for (n = 0; n <= w; n++) begin
      if (noisy && $urandom_range(3) == 0) queue_item(CMD_PUSH, pick_pixel());
      else queue_item(CMD_DRAIN, pick_pixel());
    end
    if (noisy) repeat ($urandom_range(2)) queue_item(CMD_DRAIN, pick_pixel());
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    int unsigned w, h, n, frames, random_items;
    for (n = 0; n < LINE_DEPTH; n++) begin
      row_prev[n]  = 8'd0;
      row_prev2[n] = 8'd0;
    end
    for (n = 0; n < 9; n++) win[n / 3][n % 3] = 8'd0;
    frames = 0;
    random_items = 0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Edge kernel on a 3x3 frame: white ring around a black center gives the
    // most negative sum; open with a drain that must be ignored and push a
    // pixel in the drain tail, which counts as a drain
    configure(3, 3, MODE_EDGE);
    queue_item(CMD_DRAIN, 8'hFF);
    for (n = 0; n < 9; n++) queue_item(CMD_PUSH, (n == 4) ? 8'h00 : 8'hFF);
    queue_item(CMD_PUSH, 8'h4D);
    repeat (3) queue_item(CMD_DRAIN, 8'h00);

    // Zero geometry clamps to a single pixel; unused mode code acts as box
    recv_stall_pct = 81;
    configure(0, 0, MODE_TOP_CODE);
    queue_frame(1, 1, 1'b0, 0);

    // Shrink the height mid-frame below the outputs already produced: the
    // frame restarts before the next transaction
    send_idle_pct  = 81;
    recv_stall_pct = 0;
    configure(2, 4, MODE_GAUSSIAN);
    queue_item(CMD_PUSH, 8'hFF);
    queue_item(CMD_PUSH, 8'h00);
    repeat (3) queue_item(CMD_PUSH, pick_pixel());
    settle();
    write_reg(REG_IMAGE_HEIGHT, 1);
    queue_frame(2, 1, 1'b0, 0);

    // All-ones register values clamp to the limits. Then narrow the width
    // while the second row is part way through, so the column reached lies
    // past the new right edge; finish that frame and run a clean one
    send_idle_pct  = 0;
    recv_stall_pct = 81;
    configure(2047, 8191, MODE_LAPLACIAN);
    repeat (3) queue_item(CMD_PUSH, pick_pixel());
    settle();
    write_reg(REG_IMAGE_WIDTH, 8);
    repeat (10) queue_item(CMD_PUSH, pick_pixel());
    configure(3, 2, MODE_SHARPEN);
    queue_item(CMD_PUSH, pick_pixel());
    queue_item(CMD_DRAIN, 8'h00);
    queue_frame(3, 2, 1'b0, 0);
    recv_stall_pct = 0;

    // Random frames, mostly small; hold each idling phase for three frames
    while (random_items < RANDOM_ITEMS) begin
      case ((frames / 3) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 81; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 81; end
        default: begin send_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      if ($urandom_range(9) == 0) begin
        w = $urandom_range(64, 13);
        h = $urandom_range(3, 1);
      end else begin
        w = $urandom_range(12, 1);
        h = $urandom_range(8, 1);
      end
      configure(w, h, MODE_W'($urandom_range(7)));
      queue_frame(w, h, 1'b1, ($urandom_range(3) == 0) ? $urandom_range(w * h, 1) : 0);
      random_items += w * h + w + 1;
      frames++;
    end

    // Wait out the tail of the stream and the pipeline, then report
    settle();
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hang: far beyond the slowest legal run
  initial begin
    #(5_000_000);
    $display("Mismatches found");
    $finish;
  end

endmodule

FILE: kernel3x3_convolution.f
rtl/kc3_pkg.sv
rtl/kc3_ctrl.sv
rtl/kc3_line_mem.sv
rtl/kc3_filter.sv
rtl/kc3_out_fifo.sv
rtl/kernel3x3_convolution.sv
dv/testbench.sv
